/* design/ppc64_pkg.sv */
// Shared types, codes and helper functions for the 64-bit PowerPC integer subset core.
// Used by the front queue, the execute back end, the top level and the port checker.
package ppc64_pkg;

    // Request kinds reported on the result channel
    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_STORE = 2'd2;
    localparam logic [1:0] REQ_PROBE = 2'd3;

    // Stop reasons
    localparam logic [2:0] STOP_RUNNING     = 3'd0;
    localparam logic [2:0] STOP_FAULT       = 3'd1;
    localparam logic [2:0] STOP_SYSCALL     = 3'd2;
    localparam logic [2:0] STOP_HLE         = 3'd3;
    localparam logic [2:0] STOP_UNSUPPORTED = 3'd4;
    localparam logic [2:0] STOP_LIMIT       = 3'd5;

    // Item kinds on the input channel
    localparam logic OP_FETCH    = 1'b0;
    localparam logic OP_RESPONSE = 1'b1;

    // Configuration register indexes
    localparam logic [7:0] CFG_START_PC = 8'd0;
    localparam logic [7:0] CFG_LIMIT    = 8'd1;

    // Primary opcodes
    localparam logic [5:0] PO_MULLI  = 6'd7;
    localparam logic [5:0] PO_CMPLI  = 6'd10;
    localparam logic [5:0] PO_CMPI   = 6'd11;
    localparam logic [5:0] PO_ADDI   = 6'd14;
    localparam logic [5:0] PO_ADDIS  = 6'd15;
    localparam logic [5:0] PO_BC     = 6'd16;
    localparam logic [5:0] PO_SC     = 6'd17;
    localparam logic [5:0] PO_B      = 6'd18;
    localparam logic [5:0] PO_XL     = 6'd19;
    localparam logic [5:0] PO_ORI    = 6'd24;
    localparam logic [5:0] PO_ORIS   = 6'd25;
    localparam logic [5:0] PO_XORI   = 6'd26;
    localparam logic [5:0] PO_ANDI   = 6'd28;
    localparam logic [5:0] PO_ANDIS  = 6'd29;
    localparam logic [5:0] PO_MD     = 6'd30;
    localparam logic [5:0] PO_X31    = 6'd31;
    localparam logic [5:0] PO_LWZ    = 6'd32;
    localparam logic [5:0] PO_LBZ    = 6'd34;
    localparam logic [5:0] PO_STW    = 6'd36;
    localparam logic [5:0] PO_STB    = 6'd38;
    localparam logic [5:0] PO_DS_LD  = 6'd58;
    localparam logic [5:0] PO_DS_ST  = 6'd62;

    // Extended opcodes
    localparam logic [9:0] XO_BCLR  = 10'd16;
    localparam logic [9:0] XO_BCCTR = 10'd528;
    localparam logic [9:0] XO_CMP   = 10'd0;
    localparam logic [9:0] XO_CMPL  = 10'd32;
    localparam logic [9:0] XO_SUBF  = 10'd40;
    localparam logic [9:0] XO_ADD   = 10'd266;
    localparam logic [9:0] XO_MFSPR = 10'd339;
    localparam logic [9:0] XO_OR    = 10'd444;
    localparam logic [9:0] XO_MTSPR = 10'd467;
    localparam logic [9:0] XO_EXTSW = 10'd986;

    localparam logic [9:0] SPR_LR  = 10'd8;
    localparam logic [9:0] SPR_CTR = 10'd9;

    typedef struct packed {
        logic        operation;
        logic [31:0] instr_word;
        logic        fetch_ok;
        logic [63:0] mem_data;
        logic        mem_ok;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  request_kind;
        logic [31:0] mem_address;
        logic [3:0]  access_size;
        logic [63:0] store_value;
        logic [31:0] next_pc;
        logic [2:0]  stop_code;
        logic [31:0] executed_count;
    } out_item_t;

    // Queue head handed from the front to the back end
    typedef struct packed {
        logic     valid;
        logic     is_fetch;
        in_item_t item;
    } q_head_t;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    // Write one CR field; SO always reads as zero
    function automatic logic [31:0] cr_set(input logic [31:0] cr, input logic [2:0] crf,
                                           input logic lt, input logic gt, input logic eq);
        logic [31:0] r;
        r = cr;
        for (int k = 0; k < 8; k++)
        begin
            if (crf == 3'(k))
            begin
                r[31 - 4 * k -: 4] = {lt, gt, eq, 1'b0};
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] cr_cmp_s(input logic [31:0] cr, input logic [2:0] crf,
                                             input logic [63:0] a, input logic [63:0] b);
        return cr_set(cr, crf, $signed(a) < $signed(b), $signed(a) > $signed(b), a == b);
    endfunction

    function automatic logic [31:0] cr_cmp_u(input logic [31:0] cr, input logic [2:0] crf,
                                             input logic [63:0] a, input logic [63:0] b);
        return cr_set(cr, crf, a < b, a > b, a == b);
    endfunction

endpackage

/* design/powerpc64_integer_subset_core.sv */
// Top level of the 64-bit PowerPC integer subset core.
// Depends on ppc64_pkg, ppc64_front and ppc64_back.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): fetch beats carry an
//   instruction word, response beats answer the load, store or probe request
//   shown on the previous result. Output channel (out_valid / out_stall /
//   out_data): one result beat per input beat, in order.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
//   the start PC, index 1 the instruction limit; write only while idle.
//   cfg_ready is always high.
//   An accepted beat is written into a queue slot, waits until it is the queue
//   head, is executed there, and its result is registered in the result
//   register that drives out_data.
//   Throughput: one beat per cycle while the receiver does not stall, set by
//   the execute stage that reads and writes the register file.
//   Reset clears all architectural state, the queue and the result valid flag;
//   the PC restarts at zero and the limit at all ones.
//   When the receiver stalls, the result register holds; the two-entry queue
//   keeps taking beats until full, then in_stall rises.
module powerpc64_integer_subset_core #(
    parameter int NUM_GPRS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ppc64_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ppc64_pkg::out_item_t out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    ppc64_pkg::q_head_t head;
    logic               pop;

    assign cfg_ready = 1'b1;

    ppc64_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .head     (head),
        .pop      (pop)
    );

    ppc64_back #(
        .NUM_GPRS (NUM_GPRS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

/* design/ppc64_front.sv */
// Front end: accepts input beats into a two-entry queue and tags fetch beats.
// Depends on ppc64_pkg.
module ppc64_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ppc64_pkg::in_item_t in_data,
    output ppc64_pkg::q_head_t  head,
    input  logic                pop
);

    ppc64_pkg::in_item_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       take;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign take     = pop && (count_reg != 2'd0);

    // Present the oldest beat, classified by kind
    always_comb
    begin
        head.valid    = (count_reg != 2'd0);
        head.item     = slot_reg[rd_ptr_reg];
        head.is_fetch = (slot_reg[rd_ptr_reg].operation == ppc64_pkg::OP_FETCH);
    end

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold payload in the queue slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

/* design/ppc64_back.sv */
// Back end: executes one queued beat per cycle, unless a held result is stalled, on
// the architectural state and registers the result beat. Depends on ppc64_pkg.
module ppc64_back #(
    parameter int NUM_GPRS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ppc64_pkg::q_head_t   head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ppc64_pkg::out_item_t out_data,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    logic [63:0] gpr_reg [NUM_GPRS];
    logic [31:0] start_pc_reg;
    logic [31:0] limit_reg;
    logic [31:0] cr_reg, cr_next;
    logic [63:0] lr_reg, lr_next;
    logic [63:0] ctr_reg, ctr_next;
    logic [31:0] pc_reg, pc_next;
    logic [2:0]  halt_reg, halt_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] lw_reg, lw_next;
    logic [1:0]  pk_reg, pk_next;
    logic [4:0]  pt_reg, pt_next;
    logic [4:0]  pb_reg, pb_next;
    logic [31:0] pa_reg, pa_next;
    logic [31:0] po_reg, po_next;
    logic        out_valid_reg;
    ppc64_pkg::out_item_t out_reg, out_next;

    logic        w0_en, w1_en;
    logic [4:0]  w0_idx, w1_idx;
    logic [63:0] w0_val, w1_val;
    logic        fire;

    assign fire      = head.valid && (!out_valid_reg || !out_stall);
    assign pop       = fire;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Decode and execute the head beat
    always_comb
    begin
        logic [31:0] w;
        logic [5:0]  prim;
        logic [4:0]  fd, fa, fb;
        logic [63:0] rd, ra, rb, ra0, simm, zimm, res, base, sum, disp64;
        logic [2:0]  crf;
        logic        wide, upd, ctr_ok, cond_ok, take_br, rec;
        logic [9:0]  sub, sprn;
        logic [31:0] dest;
        logic [5:0]  sh, mb;
        logic [127:0] rot;
        logic        do_issue;
        logic [1:0]  issue_kind;
        logic [3:0]  size;
        logic [63:0] src;

        cr_next = cr_reg; lr_next = lr_reg; ctr_next = ctr_reg; pc_next = pc_reg;
        halt_next = halt_reg; cnt_next = cnt_reg; lw_next = lw_reg; pk_next = pk_reg;
        pt_next = pt_reg; pb_next = pb_reg; pa_next = pa_reg; po_next = po_reg;
        w0_en = 1'b0; w0_idx = '0; w0_val = '0;
        w1_en = 1'b0; w1_idx = '0; w1_val = '0;

        w    = head.item.instr_word;
        prim = w[31:26];
        fd   = w[25:21];
        fa   = w[20:16];
        fb   = w[15:11];
        rd   = gpr_reg[fd];
        ra   = gpr_reg[fa];
        rb   = gpr_reg[fb];
        ra0  = (fa == 5'd0) ? 64'd0 : ra;
        simm = ppc64_pkg::sx16(w[15:0]);
        zimm = {48'd0, w[15:0]};
        crf  = w[25:23];
        wide = w[21];
        sub  = w[10:1];
        sprn = {w[15:11], w[20:16]};
        res = '0; base = '0; sum = '0; disp64 = '0; dest = '0;
        ctr_ok = 1'b0; cond_ok = 1'b0; take_br = 1'b0; rec = 1'b0;
        sh = '0; mb = '0; rot = '0; do_issue = 1'b0; issue_kind = ppc64_pkg::REQ_NONE;
        upd = (lw_reg[1:0] == 2'd1);
        size = '0; src = '0;

        if (fire && halt_reg == ppc64_pkg::STOP_RUNNING)
        begin
            if (head.is_fetch && pk_reg == ppc64_pkg::REQ_NONE)
            begin
                if (cnt_reg >= limit_reg)
                begin
                    halt_next = ppc64_pkg::STOP_LIMIT;
                end
                else if (pc_reg[1:0] != 2'd0 || !head.item.fetch_ok)
                begin
                    halt_next = ppc64_pkg::STOP_FAULT;
                end
                else
                begin
                    lw_next  = w;
                    cnt_next = cnt_reg + 32'd1;
                    pc_next  = pc_reg + 32'd4;
                    case (prim)
                        ppc64_pkg::PO_MULLI:
                        begin
                            // 64x16 unsigned product, corrected for a negative immediate
                            w0_en = 1'b1; w0_idx = fd;
                            w0_val = ra * w[15:0] - (w[15] ? {ra[47:0], 16'd0} : 64'd0);
                        end
                        ppc64_pkg::PO_CMPLI:
                            cr_next = ppc64_pkg::cr_cmp_u(cr_reg, crf,
                                          wide ? ra : {32'd0, ra[31:0]}, zimm);
                        ppc64_pkg::PO_CMPI:
                            cr_next = ppc64_pkg::cr_cmp_s(cr_reg, crf,
                                          wide ? ra : ppc64_pkg::sx32(ra), simm);
                        ppc64_pkg::PO_ADDI:
                        begin
                            w0_en = 1'b1; w0_idx = fd; w0_val = ra0 + simm;
                        end
                        ppc64_pkg::PO_ADDIS:
                        begin
                            w0_en = 1'b1; w0_idx = fd; w0_val = ra0 + (simm << 16);
                        end
                        ppc64_pkg::PO_BC, ppc64_pkg::PO_XL:
                        begin
                            if (prim == ppc64_pkg::PO_XL && sub != ppc64_pkg::XO_BCLR
                                && sub != ppc64_pkg::XO_BCCTR)
                            begin
                                halt_next = ppc64_pkg::STOP_UNSUPPORTED;
                            end
                            else
                            begin
                                // For bclr / bcctr the branch target comes from the old LR / CTR
                                if (prim == ppc64_pkg::PO_BC)
                                    dest = w[1] ? {{16{w[15]}}, w[15:2], 2'b00}
                                                : pc_reg + {{16{w[15]}}, w[15:2], 2'b00};
                                else if (sub == ppc64_pkg::XO_BCLR)
                                    dest = {lr_reg[31:2], 2'b00};
                                else
                                    dest = {ctr_reg[31:2], 2'b00};
                                if (w[0])
                                    lr_next = {32'd0, pc_reg + 32'd4};
                                if (!fd[2])
                                    ctr_next = ctr_reg - 64'd1;
                                ctr_ok  = fd[2] || ((ctr_next != 64'd0) != fd[1]);
                                cond_ok = fd[4] || (cr_reg[5'd31 - fa] == fd[3]);
                                take_br = ctr_ok && cond_ok;
                                if (take_br)
                                begin
                                    if (prim == ppc64_pkg::PO_XL && sub == ppc64_pkg::XO_BCCTR)
                                    begin
                                        pk_next = ppc64_pkg::REQ_PROBE;
                                        pt_next = fd; pb_next = fa;
                                        pa_next = dest; po_next = pc_reg;
                                    end
                                    else
                                    begin
                                        pc_next = dest;
                                    end
                                end
                            end
                        end
                        ppc64_pkg::PO_SC:
                            halt_next = ppc64_pkg::STOP_SYSCALL;
                        ppc64_pkg::PO_B:
                        begin
                            if (w[0])
                                lr_next = {32'd0, pc_reg + 32'd4};
                            dest = {{6{w[25]}}, w[25:2], 2'b00};
                            pc_next = w[1] ? dest : pc_reg + dest;
                        end
                        ppc64_pkg::PO_ORI:
                        begin
                            w0_en = 1'b1; w0_idx = fa; w0_val = rd | zimm;
                        end
                        ppc64_pkg::PO_ORIS:
                        begin
                            w0_en = 1'b1; w0_idx = fa; w0_val = rd | (zimm << 16);
                        end
                        ppc64_pkg::PO_XORI:
                        begin
                            w0_en = 1'b1; w0_idx = fa; w0_val = rd ^ zimm;
                        end
                        ppc64_pkg::PO_ANDI, ppc64_pkg::PO_ANDIS:
                        begin
                            res = rd & ((prim == ppc64_pkg::PO_ANDI) ? zimm : (zimm << 16));
                            w0_en = 1'b1; w0_idx = fa; w0_val = res;
                            cr_next = ppc64_pkg::cr_cmp_s(cr_reg, 3'd0, res, 64'd0);
                        end
                        ppc64_pkg::PO_MD:
                        begin
                            if (w[4:2] == 3'd0)
                            begin
                                sh  = {w[1], fb};
                                mb  = {w[5], w[10:6]};
                                rot = {rd, rd} << sh;
                                res = rot[127:64] & ({64{1'b1}} >> mb);
                                w0_en = 1'b1; w0_idx = fa; w0_val = res;
                                if (w[0])
                                    cr_next = ppc64_pkg::cr_cmp_s(cr_reg, 3'd0, res, 64'd0);
                            end
                            else
                            begin
                                halt_next = ppc64_pkg::STOP_UNSUPPORTED;
                            end
                        end
                        ppc64_pkg::PO_X31:
                        begin
                            case (sub)
                                ppc64_pkg::XO_CMP:
                                    cr_next = ppc64_pkg::cr_cmp_s(cr_reg, crf,
                                                  wide ? ra : ppc64_pkg::sx32(ra),
                                                  wide ? rb : ppc64_pkg::sx32(rb));
                                ppc64_pkg::XO_CMPL:
                                    cr_next = ppc64_pkg::cr_cmp_u(cr_reg, crf,
                                                  wide ? ra : {32'd0, ra[31:0]},
                                                  wide ? rb : {32'd0, rb[31:0]});
                                ppc64_pkg::XO_SUBF:
                                begin
                                    res = rb - ra; w0_en = 1'b1; w0_idx = fd; rec = 1'b1;
                                end
                                ppc64_pkg::XO_ADD:
                                begin
                                    res = ra + rb; w0_en = 1'b1; w0_idx = fd; rec = 1'b1;
                                end
                                ppc64_pkg::XO_OR:
                                begin
                                    res = rd | rb; w0_en = 1'b1; w0_idx = fa; rec = 1'b1;
                                end
                                ppc64_pkg::XO_EXTSW:
                                begin
                                    res = ppc64_pkg::sx32(rd); w0_en = 1'b1; w0_idx = fa;
                                    rec = 1'b1;
                                end
                                ppc64_pkg::XO_MFSPR:
                                begin
                                    if (sprn == ppc64_pkg::SPR_LR)
                                    begin
                                        w0_en = 1'b1; w0_idx = fd; w0_val = lr_reg;
                                    end
                                    else if (sprn == ppc64_pkg::SPR_CTR)
                                    begin
                                        w0_en = 1'b1; w0_idx = fd; w0_val = ctr_reg;
                                    end
                                    else
                                        halt_next = ppc64_pkg::STOP_UNSUPPORTED;
                                end
                                ppc64_pkg::XO_MTSPR:
                                begin
                                    if (sprn == ppc64_pkg::SPR_LR)
                                        lr_next = rd;
                                    else if (sprn == ppc64_pkg::SPR_CTR)
                                        ctr_next = rd;
                                    else
                                        halt_next = ppc64_pkg::STOP_UNSUPPORTED;
                                end
                                default:
                                    halt_next = ppc64_pkg::STOP_UNSUPPORTED;
                            endcase
                            if (rec)
                            begin
                                w0_val = res;
                                if (w[0])
                                    cr_next = ppc64_pkg::cr_cmp_s(cr_reg, 3'd0, res, 64'd0);
                            end
                        end
                        ppc64_pkg::PO_LWZ, ppc64_pkg::PO_LBZ:
                        begin
                            do_issue = 1'b1; issue_kind = ppc64_pkg::REQ_LOAD; disp64 = simm;
                        end
                        ppc64_pkg::PO_STW, ppc64_pkg::PO_STB:
                        begin
                            do_issue = 1'b1; issue_kind = ppc64_pkg::REQ_STORE; disp64 = simm;
                        end
                        ppc64_pkg::PO_DS_LD:
                        begin
                            if (w[1:0] == 2'd3)
                                halt_next = ppc64_pkg::STOP_UNSUPPORTED;
                            else
                            begin
                                do_issue = 1'b1; issue_kind = ppc64_pkg::REQ_LOAD;
                                disp64 = ppc64_pkg::sx16({w[15:2], 2'b00});
                            end
                        end
                        ppc64_pkg::PO_DS_ST:
                        begin
                            if (w[1:0] > 2'd1)
                                halt_next = ppc64_pkg::STOP_UNSUPPORTED;
                            else
                            begin
                                do_issue = 1'b1; issue_kind = ppc64_pkg::REQ_STORE;
                                disp64 = ppc64_pkg::sx16({w[15:2], 2'b00});
                            end
                        end
                        default:
                            halt_next = ppc64_pkg::STOP_UNSUPPORTED;
                    endcase
                    // Form the effective address; fault above 32 bits
                    if (do_issue)
                    begin
                        base = ra0;
                        sum  = base + disp64;
                        if (sum[63:32] != 32'd0)
                            halt_next = ppc64_pkg::STOP_FAULT;
                        else
                        begin
                            pk_next = issue_kind; pt_next = fd; pb_next = fa;
                            pa_next = sum[31:0]; po_next = pc_reg;
                        end
                    end
                    if (halt_next == ppc64_pkg::STOP_RUNNING && pk_next == ppc64_pkg::REQ_NONE
                        && cnt_next >= limit_reg)
                        halt_next = ppc64_pkg::STOP_LIMIT;
                end
            end
            else if (!head.is_fetch && pk_reg != ppc64_pkg::REQ_NONE)
            begin
                // Retire the outstanding request
                pk_next = ppc64_pkg::REQ_NONE;
                if (pk_reg == ppc64_pkg::REQ_PROBE)
                begin
                    if (head.item.mem_ok)
                        pc_next = pa_reg;
                    else
                    begin
                        pc_next = po_reg; halt_next = ppc64_pkg::STOP_HLE;
                    end
                end
                else if (!head.item.mem_ok)
                begin
                    halt_next = ppc64_pkg::STOP_FAULT;
                end
                else if (pk_reg == ppc64_pkg::REQ_LOAD)
                begin
                    w0_en = 1'b1; w0_idx = pt_reg;
                    if (lw_reg[31:26] == ppc64_pkg::PO_LBZ)
                        w0_val = {56'd0, head.item.mem_data[7:0]};
                    else if (lw_reg[31:26] == ppc64_pkg::PO_LWZ)
                        w0_val = {32'd0, head.item.mem_data[31:0]};
                    else if (lw_reg[1:0] == 2'd2)
                        w0_val = ppc64_pkg::sx32(head.item.mem_data);
                    else
                    begin
                        w0_val = head.item.mem_data;
                        if (upd)
                        begin
                            w1_en = 1'b1; w1_idx = pb_reg; w1_val = {32'd0, pa_reg};
                        end
                    end
                end
                else if (lw_reg[31:26] == ppc64_pkg::PO_DS_ST && upd)
                begin
                    w0_en = 1'b1; w0_idx = pb_reg; w0_val = {32'd0, pa_reg};
                end
                if (halt_next == ppc64_pkg::STOP_RUNNING && cnt_reg >= limit_reg)
                    halt_next = ppc64_pkg::STOP_LIMIT;
            end
        end

        // Build the result beat from the updated state
        src = gpr_reg[pt_next];
        if (pk_next == ppc64_pkg::REQ_PROBE)
            size = 4'd4;
        else if (pk_next != ppc64_pkg::REQ_NONE)
        begin
            if (lw_next[31:26] == ppc64_pkg::PO_LBZ || lw_next[31:26] == ppc64_pkg::PO_STB)
                size = 4'd1;
            else if (lw_next[31:26] == ppc64_pkg::PO_LWZ
                     || lw_next[31:26] == ppc64_pkg::PO_STW)
                size = 4'd4;
            else if (lw_next[31:26] == ppc64_pkg::PO_DS_LD && lw_next[1:0] == 2'd2)
                size = 4'd4;
            else
                size = 4'd8;
        end
        out_next.request_kind   = pk_next;
        out_next.mem_address    = (pk_next != ppc64_pkg::REQ_NONE) ? pa_next : 32'd0;
        out_next.access_size    = size;
        out_next.store_value    = '0;
        if (pk_next == ppc64_pkg::REQ_STORE)
        begin
            if (size == 4'd1)
                out_next.store_value = {56'd0, src[7:0]};
            else if (size == 4'd4)
                out_next.store_value = {32'd0, src[31:0]};
            else
                out_next.store_value = src;
        end
        out_next.next_pc        = pc_next;
        out_next.stop_code      = halt_next;
        out_next.executed_count = cnt_next;
    end

    // Update architectural state; take configuration writes while idle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pc_reg  <= 32'd0;
            limit_reg     <= 32'hffff_ffff;
            cr_reg        <= '0;
            lr_reg        <= '0;
            ctr_reg       <= '0;
            pc_reg        <= '0;
            halt_reg      <= ppc64_pkg::STOP_RUNNING;
            cnt_reg       <= '0;
            lw_reg        <= '0;
            pk_reg        <= ppc64_pkg::REQ_NONE;
            pt_reg        <= '0;
            pb_reg        <= '0;
            pa_reg        <= '0;
            po_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_GPRS; i++)
            begin
                gpr_reg[i] <= '0;
            end
        end
        else
        begin
            if (fire)
            begin
                cr_reg <= cr_next; lr_reg <= lr_next; ctr_reg <= ctr_next;
                pc_reg <= pc_next; halt_reg <= halt_next; cnt_reg <= cnt_next;
                lw_reg <= lw_next; pk_reg <= pk_next; pt_reg <= pt_next;
                pb_reg <= pb_next; pa_reg <= pa_next; po_reg <= po_next;
                for (int i = 0; i < NUM_GPRS; i++)
                begin
                    if (w0_en && w0_idx == 5'(i))
                        gpr_reg[i] <= w0_val;
                    if (w1_en && w1_idx == 5'(i))
                        gpr_reg[i] <= w1_val;
                end
            end
            else if (cfg_we)
            begin
                if (cfg_index == ppc64_pkg::CFG_START_PC)
                begin
                    start_pc_reg <= cfg_data;
                    if (halt_reg == ppc64_pkg::STOP_RUNNING && pk_reg == ppc64_pkg::REQ_NONE
                        && cnt_reg == 32'd0)
                        pc_reg <= cfg_data;
                end
                else if (cfg_index == ppc64_pkg::CFG_LIMIT)
                begin
                    limit_reg <= cfg_data;
                end
            end
            // Hold a stalled result; drop it once taken
            if (fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_reg <= out_next;
    end

endmodule

/* design/ppc64_checker.sv */
// Port checker for the PowerPC integer subset core, bound to the top level.
// Depends on ppc64_pkg.
module ppc64_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input ppc64_pkg::out_item_t out_data
);

    // Hold a stalled result beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped under stall");

    // No request: address, size and store data read zero
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.request_kind == ppc64_pkg::REQ_NONE |->
            out_data.mem_address == 32'd0 && out_data.access_size == 4'd0
            && out_data.store_value == 64'd0)
        else $error("idle result carries request fields");

    // An outstanding request implies a running core
    a_req_running: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.request_kind != ppc64_pkg::REQ_NONE |->
            out_data.stop_code == ppc64_pkg::STOP_RUNNING)
        else $error("request shown while stopped");

    // Only stores carry data
    a_store_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.request_kind != ppc64_pkg::REQ_STORE |->
            out_data.store_value == 64'd0)
        else $error("store data on a non-store result");

endmodule

bind powerpc64_integer_subset_core ppc64_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
